@@ rtl/core/wvs_pkg.sv @@
// Package: shared types, constants and command structs for the vruntime scheduler
`timescale 1ns / 1ps
package wvs_pkg;
   localparam int SLOTS      = 16;
   localparam int SLOT_W     = 4;
   localparam int CNT_W      = 5;
   localparam int TOTAL_W    = 20;
   localparam int VR_W       = 32;
   localparam int WEIGHT_W   = 16;
   localparam int SLICE_W    = 8;
   localparam int BASE_SHIFT = 10;

   typedef enum logic [1:0] {
      ACT_ENQ  = 2'd0,
      ACT_DEQ  = 2'd1,
      ACT_PICK = 2'd2,
      ACT_TICK = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV1,
      ST_DIV2,
      ST_DONE,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // latch request, run simple ops
      logic scan_start;
      logic scan_step;
      logic div1_start;
      logic div_step;
      logic div2_start;
      logic commit;     // write back pick results
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_pick;
      logic scan_last;
      logic found;
      logic div_done;
   } sts_type;
endpackage

@@ rtl/core/wvs_if.sv @@
// Interfaces: request, response and register write channels
`timescale 1ns / 1ps
interface wvs_req_if;
   import wvs_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          action;
   logic [SLOT_W-1:0]   slot;
   logic [WEIGHT_W-1:0] weight;
   modport source (output valid, action, slot, weight, input ready);
   modport sink   (input valid, action, slot, weight, output ready);
endinterface

interface wvs_rsp_if;
   import wvs_pkg::*;
   logic               valid;
   logic               ready;
   logic [SLOT_W-1:0]  picked_slot;
   logic               picked_valid;
   logic [SLICE_W-1:0] granted_slice;
   logic               resched;
   logic               status;
   logic [CNT_W-1:0]   queued_count;
   modport source (output valid, picked_slot, picked_valid, granted_slice, resched,
                   status, queued_count, input ready);
   modport sink   (input valid, picked_slot, picked_valid, granted_slice, resched,
                   status, queued_count, output ready);
endinterface

interface wvs_csr_if;
   import wvs_pkg::*;
   logic               valid;
   logic               ready;
   logic [SLICE_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/weighted_vruntime_scheduler.sv @@
// Top level: weighted virtual-runtime scheduler
`timescale 1ns / 1ps
// One request at a time. Enqueue, dequeue and tick go from idle through the done state,
// which loads the response register, to the output state. A pick scans the 16 slots
// one per cycle, then runs two 32-step restoring divisions on a shared divider (charge,
// then slice share) before the done state. A pick with no queued slot skips the
// divisions. Once the response is taken the block returns to idle, where it accepts
// the next request. The user must write max_slice through csr_ only while idle; the
// block itself does not enforce it.
module weighted_vruntime_scheduler import wvs_pkg::*; (
   input logic      clock,
   input logic      reset,
   wvs_req_if.sink  req,
   wvs_rsp_if.source rsp,
   wvs_csr_if.sink  csr
);
   cmd_type cmd;
   sts_type sts;

   assign csr.ready = 1'b1;

   wvs_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd(cmd), .sts(sts)
   );

   wvs_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_action(req.action), .req_slot(req.slot), .req_weight(req.weight),
      .csr_we(csr.valid), .csr_data(csr.data),
      .rsp_picked_slot(rsp.picked_slot), .rsp_picked_valid(rsp.picked_valid),
      .rsp_granted_slice(rsp.granted_slice), .rsp_resched(rsp.resched),
      .rsp_status(rsp.status), .rsp_queued_count(rsp.queued_count)
   );

   // no request taken while a response waits
   assert property (@(posedge clock) disable iff (reset) rsp.valid |-> !req.ready)
      else $error("request accepted while response pending");
   // a response with no picked slot never grants a slice
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.picked_valid |-> rsp.granted_slice == '0)
      else $error("slice granted without pick");
   // queue count never exceeds slot count
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.queued_count <= CNT_W'(SLOTS))
      else $error("queued count overflow");
endmodule

@@ rtl/core/wvs_ctrl.sv @@
// Controller: sequences request handling, slot scan and the two divisions
`timescale 1ns / 1ps
module wvs_ctrl import wvs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);
   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = sts.is_pick ? ST_SCAN : ST_DONE;
         ST_SCAN: if (sts.scan_last) state_in = sts.found ? ST_DIV1 : ST_DONE;
         ST_DIV1: if (sts.div_done) state_in = ST_DIV2;
         ST_DIV2: if (sts.div_done) state_in = ST_DONE;
         ST_DONE: state_in = ST_OUT;
         ST_OUT:  if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
            cmd.scan_start = req_valid;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.div1_start = sts.scan_last;
         end
         ST_DIV1: begin
            cmd.div_step = 1'b1;
            cmd.div2_start = sts.div_done;
         end
         ST_DIV2: begin
            cmd.div_step = 1'b1;
         end
         ST_DONE: begin
            cmd.commit = 1'b1;
            cmd.rsp_load = 1'b1;
         end
         ST_OUT:  rsp_valid = 1'b1;
         default: ;
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

@@ rtl/core/wvs_dp.sv @@
// Datapath: slot table, min-vruntime scan and restoring divider
`timescale 1ns / 1ps
module wvs_dp import wvs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic [1:0]          req_action,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [WEIGHT_W-1:0] req_weight,
   input  logic                csr_we,
   input  logic [SLICE_W-1:0]  csr_data,
   output logic [SLOT_W-1:0]   rsp_picked_slot,
   output logic                rsp_picked_valid,
   output logic [SLICE_W-1:0]  rsp_granted_slice,
   output logic                rsp_resched,
   output logic                rsp_status,
   output logic [CNT_W-1:0]    rsp_queued_count
);
   logic [SLOTS-1:0]    queued_ff;
   logic [WEIGHT_W-1:0] weight_ff [SLOTS];
   logic [VR_W-1:0]     vr_ff     [SLOTS];
   logic [VR_W-1:0]     run_ff    [SLOTS];
   logic [SLICE_W-1:0]  slice_ff  [SLOTS];
   logic [TOTAL_W-1:0]  total_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [SLICE_W-1:0]  max_slice_ff;

   logic [SLOT_W-1:0]   idx_ff;     // scan position
   logic [SLOT_W-1:0]   best_ff;
   logic                found_ff;
   logic                resched_ff, status_ff;

   // divider: quotient/remainder shift register
   logic [VR_W-1:0]     dvd_ff;     // dividend shifting into quotient
   logic [VR_W-1:0]     rem_ff;
   logic [VR_W-1:0]     dvs_ff;
   logic [5:0]          dcnt_ff;
   logic [VR_W-1:0]     q1_ff;      // charge quotient

   logic [VR_W-1:0]     prod;
   logic [VR_W:0]       rem_sh, rem_sub;
   logic                better;
   logic [VR_W-1:0]     diff;
   logic [WEIGHT_W-1:0] pw;
   logic [SLICE_W-1:0]  slice_new;
   logic [SLOT_W-1:0]   s;

   assign s    = req_slot;
   assign pw   = weight_ff[best_ff];
   assign prod = {run_ff[best_ff][VR_W-BASE_SHIFT-1:0], {BASE_SHIFT{1'b0}}};
   assign diff = vr_ff[idx_ff] - vr_ff[best_ff];
   assign better = queued_ff[idx_ff] && (!found_ff || diff[VR_W-1]);
   assign rem_sh  = {rem_ff, dvd_ff[VR_W-1]};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   assign sts.is_pick  = (req_action == ACT_PICK);
   assign sts.scan_last = (idx_ff == SLOT_W'(SLOTS-1));
   assign sts.found    = found_ff || better;
   assign sts.div_done = (dcnt_ff == 6'd0);

   // granted slice: second quotient saturated, or full period
   always_comb begin
      if (pw == '0 || total_ff == '0) slice_new = max_slice_ff;
      else if (dvd_ff[VR_W-1:SLICE_W] != '0) slice_new = '1;
      else slice_new = dvd_ff[SLICE_W-1:0];
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) max_slice_ff <= SLICE_W'(5);
      else if (csr_we) max_slice_ff <= csr_data;
   end

   // scan and divider
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         idx_ff <= '0;
         best_ff <= '0;
         found_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         if (better) begin
            best_ff <= idx_ff;
            found_ff <= 1'b1;
         end
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.div1_start) begin
         // best not final yet when the last slot wins: use the chosen index
         dvd_ff <= better ? {run_ff[idx_ff][VR_W-BASE_SHIFT-1:0], {BASE_SHIFT{1'b0}}}
                          : prod;
         dvs_ff <= better ? VR_W'(weight_ff[idx_ff]) : VR_W'(pw);
         rem_ff <= '0;
         dcnt_ff <= 6'd32;
      end else if (cmd.div2_start) begin
         q1_ff <= dvd_ff;
         dvd_ff <= VR_W'(max_slice_ff) * VR_W'(pw);
         dvs_ff <= VR_W'(total_ff);
         rem_ff <= '0;
         dcnt_ff <= 6'd32;
      end else if (cmd.div_step && dcnt_ff != 6'd0) begin
         if (!rem_sub[VR_W]) begin
            rem_ff <= rem_sub[VR_W-1:0];
            dvd_ff <= {dvd_ff[VR_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[VR_W-1:0];
            dvd_ff <= {dvd_ff[VR_W-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff - 1'b1;
      end
   end

   // slot table updates
   always_ff @(posedge clock) begin
      if (reset) begin
         queued_ff <= '0;
         total_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            weight_ff[i] <= '0;
            vr_ff[i] <= '0;
            run_ff[i] <= '0;
            slice_ff[i] <= '0;
         end
      end else begin
         if (cmd.load) begin
            resched_ff <= 1'b0;
            status_ff <= 1'b0;
            case (req_action)
               ACT_ENQ: begin
                  if (queued_ff[s]) status_ff <= 1'b1;
                  else begin
                     queued_ff[s] <= 1'b1;
                     weight_ff[s] <= req_weight;
                     total_ff <= total_ff + TOTAL_W'(req_weight);
                     count_ff <= count_ff + 1'b1;
                  end
               end
               ACT_DEQ: begin
                  if (!queued_ff[s]) status_ff <= 1'b1;
                  else begin
                     queued_ff[s] <= 1'b0;
                     total_ff <= total_ff - TOTAL_W'(weight_ff[s]);
                     count_ff <= count_ff - 1'b1;
                  end
               end
               ACT_TICK: begin
                  if (slice_ff[s] != '0) begin
                     slice_ff[s] <= slice_ff[s] - 1'b1;
                     run_ff[s] <= run_ff[s] + 1'b1;
                  end
                  resched_ff <= (slice_ff[s] <= SLICE_W'(1));
               end
               default: ;
            endcase
         end
         // charge vruntime and grant slice
         if (cmd.commit && found_ff) begin
            vr_ff[best_ff] <= vr_ff[best_ff] + ((pw == '0) ? prod : q1_ff);
            slice_ff[best_ff] <= slice_new;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_picked_slot <= found_ff ? best_ff : '0;
         rsp_picked_valid <= found_ff;
         rsp_granted_slice <= found_ff ? slice_new : '0;
         rsp_resched <= resched_ff;
         rsp_status <= status_ff;
         rsp_queued_count <= count_ff;
      end
   end
endmodule

@@ dv/weighted_vruntime_scheduler_checker.sv @@
// Checker: predicts scheduler responses from observed requests and compares them
`timescale 1ns / 1ps
module weighted_vruntime_scheduler_checker import wvs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   wvs_req_if.sink   req_mon,
   wvs_rsp_if.sink   rsp_mon,
   wvs_csr_if.sink   csr_mon,
   output int        fail_count,
   output int        pending_count
);
   typedef struct packed {
      logic [SLOT_W-1:0]  picked_slot;
      logic               picked_valid;
      logic [SLICE_W-1:0] granted_slice;
      logic               resched;
      logic               status;
      logic [CNT_W-1:0]   queued_count;
   } sched_rsp_type;

   logic                    sh_queued [SLOTS];
   logic [WEIGHT_W-1:0]     sh_weight [SLOTS];
   logic [VR_W-1:0]         sh_vrt    [SLOTS];
   logic [31:0]             sh_run    [SLOTS];
   logic [SLICE_W-1:0]      sh_slice  [SLOTS];
   logic [TOTAL_W-1:0]      sh_total;
   logic [CNT_W-1:0]        sh_count;
   logic [SLICE_W-1:0]      sh_max_slice;
   sched_rsp_type           expected_rsps [$];

   assign pending_count = expected_rsps.size();

   // apply one request to the shadow scheduler and return its response
   function automatic sched_rsp_type schedule_request(action_type act,
                                                      logic [SLOT_W-1:0] s,
                                                      logic [WEIGHT_W-1:0] w);
      sched_rsp_type r;
      int best;
      logic [31:0] diff, prod, sl;
      r = '0;
      best = -1;
      case (act)
         ACT_PICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (sh_queued[i]) begin
                  diff = sh_vrt[i] - (best < 0 ? 32'd0 : sh_vrt[best]);
                  if (best < 0 || diff[31]) best = i;
               end
            end
            if (best >= 0) begin
               prod = sh_run[best] << BASE_SHIFT;
               if (sh_weight[best] == 0) begin
                  sh_vrt[best] += prod;
                  sl = sh_max_slice;
               end else begin
                  sh_vrt[best] += prod / sh_weight[best];
                  if (sh_total == 0) sl = sh_max_slice;
                  else begin
                     sl = (32'(sh_max_slice) * sh_weight[best]) / sh_total;
                     if (sl > 255) sl = 255;
                  end
               end
               sh_slice[best] = sl[7:0];
               r.picked_slot = best[SLOT_W-1:0];
               r.picked_valid = 1'b1;
               r.granted_slice = sl[7:0];
            end
         end
         ACT_ENQ: begin
            if (sh_queued[s]) r.status = 1'b1;
            else begin
               sh_queued[s] = 1'b1;
               sh_weight[s] = w;
               sh_total += w;
               sh_count++;
            end
         end
         ACT_DEQ: begin
            if (!sh_queued[s]) r.status = 1'b1;
            else begin
               sh_queued[s] = 1'b0;
               sh_total -= sh_weight[s];
               sh_count--;
            end
         end
         default: begin
            if (sh_slice[s] != 0) begin
               sh_slice[s]--;
               sh_run[s]++;
            end
            r.resched = (sh_slice[s] == 0);
         end
      endcase
      r.queued_count = sh_count;
      return r;
   endfunction

   // track requests, register writes and responses
   always @(posedge clock) begin
      sched_rsp_type got, want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            sh_queued[i] = 1'b0;
            sh_weight[i] = '0;
            sh_vrt[i]    = '0;
            sh_run[i]    = '0;
            sh_slice[i]  = '0;
         end
         sh_total     = '0;
         sh_count     = '0;
         sh_max_slice = 8'd5;
         fail_count   <= 0;
         expected_rsps.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) sh_max_slice = csr_mon.data;
         if (req_mon.valid && req_mon.ready)
            expected_rsps.push_back(schedule_request(action_type'(req_mon.action),
                                                     req_mon.slot, req_mon.weight));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.picked_slot, rsp_mon.picked_valid, rsp_mon.granted_slice,
                    rsp_mon.resched, rsp_mon.status, rsp_mon.queued_count};
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected slot=%0d v=%0d slice=%0d rs=%0d st=%0d cnt=%0d",
                           $time, want.picked_slot, want.picked_valid, want.granted_slice,
                           want.resched, want.status, want.queued_count);
                  $display("%0t:          actual   slot=%0d v=%0d slice=%0d rs=%0d st=%0d cnt=%0d",
                           $time, got.picked_slot, got.picked_valid, got.granted_slice,
                           got.resched, got.status, got.queued_count);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

@@ dv/weighted_vruntime_scheduler_test.sv @@
// Testbench top: stimulus, idling, register phases and verdict
`timescale 1ns / 1ps
module weighted_vruntime_scheduler_test;
   import wvs_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   hold_requests;
   int   hold_seen;
   int   hold_cycles;

   wvs_req_if req_ch ();
   wvs_rsp_if rsp_ch ();
   wvs_csr_if csr_ch ();

   weighted_vruntime_scheduler i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   weighted_vruntime_scheduler_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch.sink),
      .rsp_mon       (rsp_ch.sink),
      .csr_mon       (csr_ch.sink),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, or a long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles  <= 0;
         hold_seen    <= 0;
      end else if (hold_seen != hold_requests) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles  <= 400;
         hold_seen    <= hold_requests;
      end else if (hold_cycles > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles  <= hold_cycles - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // send one request, idling at random beforehand
   task automatic send_request(action_type act, int s, int w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= act;
      req_ch.slot   <= s[SLOT_W-1:0];
      req_ch.weight <= w[WEIGHT_W-1:0];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // drop the request, drain all responses, then let the block settle
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_max_slice(int value);
      wait_drained();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value[SLICE_W-1:0];
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // random traffic: enqueue, dequeue, pick and tick on random slots
   task automatic random_requests(int n);
      int roll, w;
      for (int k = 0; k < n; k++) begin
         roll = $urandom_range(99);
         case ($urandom_range(3))
            0: w = 0;
            1: w = 16'hFFFF;
            2: w = $urandom_range(2048);
            default: w = $urandom_range(16'hFFFF);
         endcase
         if (roll < 25)      send_request(ACT_ENQ, $urandom_range(15), w);
         else if (roll < 37) send_request(ACT_DEQ, $urandom_range(15), w);
         else if (roll < 60) send_request(ACT_PICK, $urandom_range(15), w);
         else                send_request(ACT_TICK, $urandom_range(15), w);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.action = ACT_ENQ;
      req_ch.slot = '0;
      req_ch.weight = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      hold_requests = 0;
      send_idle_pct = 6;
      recv_idle_pct = 55;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pick, misuse, ticks on an idle slot, weight extremes
      send_request(ACT_PICK, 0, 0);
      send_request(ACT_DEQ, 3, 0);
      send_request(ACT_TICK, 15, 16'hFFFF);
      send_request(ACT_ENQ, 0, 0);
      send_request(ACT_ENQ, 0, 5);
      send_request(ACT_ENQ, 15, 16'hFFFF);
      send_request(ACT_ENQ, 7, 1024);
      send_request(ACT_PICK, 0, 0);
      send_request(ACT_TICK, 0, 0);
      send_request(ACT_TICK, 0, 0);
      for (int k = 0; k < 6; k++) send_request(ACT_TICK, 15, 0);
      send_request(ACT_PICK, 0, 0);
      send_request(ACT_PICK, 0, 0);
      send_request(ACT_DEQ, 15, 0);
      send_request(ACT_DEQ, 15, 0);
      send_request(ACT_PICK, 0, 0);
      send_request(ACT_TICK, 7, 0);

      write_max_slice(255);
      random_requests(400);

      // long receiver hold-off while the sender keeps offering
      wait_drained();
      hold_requests = hold_requests + 1;
      random_requests(20);
      write_max_slice(1);
      send_idle_pct = 55;
      recv_idle_pct = 6;
      random_requests(400);
      write_max_slice($urandom_range(2, 254));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_requests(400);
      write_max_slice(128);
      random_requests(300);

      wait_drained();
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end
endmodule
